// ===== rtl/sfd_pkg.sv =====
// sfd_pkg: shared constants, phase codes and the result record type for the
// sync word frame deframer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    // frame delimiters and type codes
    localparam logic [7:0] SYNC_A      = 8'h5A;
    localparam logic [7:0] SYNC_B      = 8'hA5;
    localparam logic [7:0] TYPE_ROUTED = 8'h02;
    localparam logic [7:0] TYPE_FIXED  = 8'h03;

    // route index pieces
    localparam int          ROUTE_W     = 17;
    localparam logic [16:0] ROUTE_FIXED = 17'd16;

    // field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int PORT_W = 2;
    localparam int STAT_W = 2;

    // reset value of the payload limit
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1012;

    // register indexes of the configuration port
    localparam logic REG_PORT_NUMBER = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;

    // frame status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_TAIL_ERR = 2'd1;
    localparam logic [1:0] STAT_LEN_ERR  = 2'd2;

    // item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_RECORD  = 1'b1;

    // parser phase codes
    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_SRC     = 4'd2;
    localparam logic [3:0] PH_DST     = 4'd3;
    localparam logic [3:0] PH_LENH    = 4'd4;
    localparam logic [3:0] PH_LENL    = 4'd5;
    localparam logic [3:0] PH_TYPE    = 4'd6;
    localparam logic [3:0] PH_FUNC    = 4'd7;
    localparam logic [3:0] PH_PAYLOAD = 4'd8;
    localparam logic [3:0] PH_CRC0    = 4'd9;
    localparam logic [3:0] PH_CRC1    = 4'd10;
    localparam logic [3:0] PH_TAIL0   = 4'd11;
    localparam logic [3:0] PH_TAIL1   = 4'd12;

    // one result item
    typedef struct packed {
        logic              kind;
        logic [7:0]        payload_byte;
        logic [7:0]        source_addr;
        logic [7:0]        dest_addr;
        logic [7:0]        frame_type;
        logic [7:0]        function_code;
        logic [15:0]       payload_len;
        logic [16:0]       route_index;
        logic [1:0]        frame_status;
        logic              last;
    } sfd_result_t;

endpackage

`default_nettype wire

// ===== rtl/sfd_parser.sv =====
// sfd_parser: byte-wise frame phase tracker, header holding registers and
// combinational result build. Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_parser
    import sfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_accept,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [1:0]        port_number,
    input  wire logic [15:0]       max_payload_len,
    output logic                   res_valid,
    output sfd_result_t            res
);

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  src_reg, src_next;
    logic [7:0]  dst_reg, dst_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  func_reg, func_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  tail0_reg, tail0_next;

    logic [15:0] len_full;
    logic [15:0] len_minus2;
    logic [15:0] held_minus2;
    logic        len_short;
    logic        len_long;
    logic [16:0] route;

    // length checks on the low length byte
    assign len_full    = {len_reg[15:8], rx_byte};
    assign len_minus2  = len_full - 16'd2;
    assign held_minus2 = len_reg - 16'd2;
    assign len_short   = (len_full < 16'd2);
    assign len_long    = (len_minus2 > max_payload_len);

    // routing index from the held type
    always_comb
    begin
        case (type_reg)
            TYPE_ROUTED: route = {1'b1, 6'b0, port_number, func_reg};
            TYPE_FIXED:  route = ROUTE_FIXED;
            default:     route = '0;
        endcase
    end

    // phase step and result build
    always_comb
    begin
        phase_next = phase_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        type_next  = type_reg;
        func_next  = func_reg;
        len_next   = len_reg;
        count_next = count_reg;
        tail0_next = tail0_reg;
        res_valid  = 1'b0;
        res        = '0;

        case (phase_reg)
            PH_SYNC2:
            begin
                phase_next = (rx_byte == SYNC_B) ? PH_SRC : PH_HUNT;
            end
            PH_SRC:
            begin
                src_next   = rx_byte;
                phase_next = PH_DST;
            end
            PH_DST:
            begin
                dst_next   = rx_byte;
                phase_next = PH_LENH;
            end
            PH_LENH:
            begin
                len_next   = {rx_byte, 8'h00};
                phase_next = PH_LENL;
            end
            PH_LENL:
            begin
                len_next = len_full;
                if (len_short || len_long)
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_RECORD;
                    res.source_addr  = src_reg;
                    res.dest_addr    = dst_reg;
                    res.payload_len  = len_short ? 16'd0 : len_minus2;
                    res.frame_status = STAT_LEN_ERR;
                    res.last         = 1'b1;
                    phase_next       = PH_HUNT;
                end
                else
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                type_next  = rx_byte;
                phase_next = PH_FUNC;
            end
            PH_FUNC:
            begin
                func_next  = rx_byte;
                count_next = held_minus2;
                phase_next = (held_minus2 == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = rx_byte;
                count_next       = count_reg - 16'd1;
                if (count_reg == 16'd1)
                begin
                    phase_next = PH_CRC0;
                end
            end
            PH_CRC0:
            begin
                phase_next = PH_CRC1;
            end
            PH_CRC1:
            begin
                phase_next = PH_TAIL0;
            end
            PH_TAIL0:
            begin
                tail0_next = rx_byte;
                phase_next = PH_TAIL1;
            end
            PH_TAIL1:
            begin
                res_valid         = 1'b1;
                res.kind          = KIND_RECORD;
                res.source_addr   = src_reg;
                res.dest_addr     = dst_reg;
                res.frame_type    = type_reg;
                res.function_code = func_reg;
                res.payload_len   = held_minus2;
                res.route_index   = route;
                res.frame_status  = (tail0_reg == SYNC_B && rx_byte == SYNC_A)
                                    ? STAT_OK : STAT_TAIL_ERR;
                res.last          = 1'b1;
                phase_next        = PH_HUNT;
            end
            default:
            begin
                phase_next = (rx_byte == SYNC_A) ? PH_SYNC2 : PH_HUNT;
            end
        endcase

        // nothing moves without a byte
        if (!byte_accept)
        begin
            res_valid = 1'b0;
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            src_reg   <= '0;
            dst_reg   <= '0;
            type_reg  <= '0;
            func_reg  <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            tail0_reg <= '0;
        end
        else if (byte_accept)
        begin
            phase_reg <= phase_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            type_reg  <= type_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            tail0_reg <= tail0_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sync_word_frame_deframer.sv =====
// sync_word_frame_deframer: top level with configuration registers, parser
// and output register. Depends on sfd_pkg and sfd_parser.
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata: rx_byte
//  m_axis    out        m_axis_tvalid/tready      tdata: record fields, tuser: item_kind,
//                                                 tlast: last_of_frame
//  cfg       in         cfg_we (no wait)          cfg_index, cfg_data
//
// One byte is taken per cycle while s_axis_tready is high; its result, if any, shows on m_axis the next cycle.
// A single output register holds the result; a new byte is taken whenever that
// register is empty or being emptied in the same cycle.
// Reset puts the parser in sync hunting and clears its holding registers and the output valid flag.
// A stall on m_axis stops s_axis only while the output register is full.
`timescale 1ns / 1ps
`default_nettype none

module sync_word_frame_deframer
    import sfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // rx_byte[7:0]
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // payload_byte[7:0], source_addr[15:8], dest_addr[23:16], frame_type[31:24],
    // function_code[39:32], payload_len[55:40], route_index[72:56],
    // frame_status[74:73], zero fill [79:75]
    output logic [79:0]      m_axis_tdata,
    // item_kind[0]
    output logic             m_axis_tuser,
    output logic             m_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [1:0]   port_number_reg;
    logic [15:0]  max_payload_len_reg;
    logic         in_accept;
    logic         res_valid;
    sfd_result_t  res;
    logic         out_valid_reg;
    sfd_result_t  out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_number_reg     <= '0;
            max_payload_len_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PORT_NUMBER: port_number_reg     <= cfg_data[1:0];
                REG_MAX_PAYLOAD: max_payload_len_reg <= cfg_data;
                default:         port_number_reg     <= port_number_reg;
            endcase
        end
    end

    // input handshake
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    sfd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_accept     (in_accept),
        .rx_byte         (s_axis_tdata),
        .port_number     (port_number_reg),
        .max_payload_len (max_payload_len_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {5'b0, out_reg.frame_status, out_reg.route_index,
                            out_reg.payload_len, out_reg.function_code,
                            out_reg.frame_type, out_reg.dest_addr,
                            out_reg.source_addr, out_reg.payload_byte};

    // no new transaction taken while a held result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !in_accept)
        else $error("byte taken while output register stalled");

    // a record closes the frame, a payload byte never does
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("last flag disagrees with item kind");

    // a length error carries no type, function or route
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.frame_status == STAT_LEN_ERR)
        |-> (out_reg.frame_type == 8'd0 && out_reg.route_index == 17'd0))
        else $error("length error record carries header fields");

    // a result appears in the cycle after a transaction that made one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && res_valid) |=> m_axis_tvalid)
        else $error("result lost after accepted byte");

endmodule

`default_nettype wire
